// ===== rtl/bmpd_pkg.sv =====
// Package for the 24-bit BMP stream decoder: parse phases, result codes,
// header constants and the item and result types.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none
package bmpd_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 4096;
  localparam int unsigned DEF_MAX_HEIGHT = 4096;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned CMP_W   = 13;
  localparam int unsigned POS_W   = 32;

  localparam logic [7:0] SIG_B = 8'h42;
  localparam logic [7:0] SIG_M = 8'h4D;

  localparam logic [31:0] HDR_INFO   = 32'd40;
  localparam logic [31:0] HDR_CORE   = 32'd12;
  localparam logic [31:0] HDR_V2     = 32'd64;
  localparam logic [31:0] HDR_V4     = 32'd108;
  localparam logic [31:0] HDR_V5     = 32'd124;
  localparam logic [15:0] BPP_24     = 16'd24;
  localparam logic [15:0] COMP_NONE  = 16'd0;

  localparam logic [31:0] POS_OFFSET_END = 32'd13;
  localparam logic [31:0] POS_HSIZE_END  = 32'd17;
  localparam logic [31:0] POS_INFO_W_END = 32'd21;
  localparam logic [31:0] POS_INFO_H_END = 32'd25;
  localparam logic [31:0] POS_INFO_BPP   = 32'd29;
  localparam logic [31:0] POS_INFO_COMP  = 32'd31;
  localparam logic [31:0] POS_INFO_DATA  = 32'd32;
  localparam logic [31:0] POS_CORE_W_END = 32'd19;
  localparam logic [31:0] POS_CORE_H_END = 32'd21;
  localparam logic [31:0] POS_CORE_BPP   = 32'd25;
  localparam logic [31:0] POS_CORE_DATA  = 32'd26;

  typedef enum logic [2:0] {
    PH_SIG  = 3'd0,
    PH_HDR  = 3'd1,
    PH_SKIP = 3'd2,
    PH_PIX  = 3'd3,
    PH_DONE = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_PIXEL       = 3'd0,
    ST_BAD_SIG     = 3'd1,
    ST_HDR_VERSION = 3'd2,
    ST_HDR_UNKNOWN = 3'd3,
    ST_NOT_24BPP   = 3'd4,
    ST_COMPRESSED  = 3'd5,
    ST_BAD_SIZE    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    CH_BLUE  = 2'd0,
    CH_GREEN = 2'd1,
    CH_RED   = 2'd2
  } chan_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               last_pixel;
    status_t            status;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/bmpd_if.sv =====
// Valid/ready channel interfaces for the BMP decoder byte input and
// pixel/status output. Depends on bmpd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface bmpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

interface bmpd_out_if
  import bmpd_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;
  logic               last_pixel;
  logic [2:0]         status;

  modport source (output valid, output red, output green, output blue, output column,
                  output row, output last_pixel, output status, input ready);
  modport sink (input valid, input red, input green, input blue, input column,
                input row, input last_pixel, input status, output ready);
endinterface
`default_nettype wire

// ===== rtl/bmp24_stream_decoder.sv =====
// Streaming decoder for uncompressed 24-bit BMP files, one byte per transaction.
// A byte passes through the input register, the parser logic and the result register
// before its result is on out_bus; throughput is one byte per cycle while out_bus.ready is high.
// Stalls come only from the result register waiting on out_bus.ready.
// Synchronous active-low reset returns the parser to the signature check at
// byte 0 and empties both registers; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module bmp24_stream_decoder
  import bmpd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bmpd_in_if.sink    in_bus,
  bmpd_out_if.source out_bus
);

  logic    adv;
  logic    item_valid;
  item_t   item;
  logic    res_valid;
  result_t res;

  bmpd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  bmpd_parser #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  bmpd_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .res_valid  (res_valid),
    .res        (res),
    .adv        (adv),
    .out_bus    (out_bus)
  );

endmodule
`default_nettype wire

// ===== rtl/bmpd_in_stage.sv =====
// Input register of the BMP decoder: captures one byte transaction and holds
// it until the parser advances. Depends on bmpd_pkg and bmpd_in_if.
`timescale 1ns / 1ps
`default_nettype none
module bmpd_in_stage
  import bmpd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  bmpd_in_if.sink    in_bus,
  input  wire logic  adv,
  output logic       item_valid,
  output item_t      item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  take;

  assign in_bus.ready = !valid_r || adv;
  assign take         = in_bus.valid && in_bus.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= '{data_byte: in_bus.data_byte, first_byte: in_bus.first_byte};
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule
`default_nettype wire

// ===== rtl/bmpd_parser.sv =====
// Header parser and pixel walker of the BMP decoder. Holds all parse state
// and turns one byte into at most one result. Depends on bmpd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bmpd_parser
  import bmpd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  adv,
  input  item_t      item,
  output logic       res_valid,
  output result_t    res
);

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned BW = $clog2(3 * MAX_WIDTH + 4);

  phase_t             phase_r,  phase_nxt;
  logic [POS_W-1:0]   pos_r,    pos_nxt;
  logic [31:0]        acc_r,    acc_nxt;
  logic [31:0]        off_r,    off_nxt;
  logic [31:0]        hlen_r,   hlen_nxt;
  logic [WW-1:0]      width_r,  width_nxt;
  logic [HW-1:0]      height_r, height_nxt;
  logic [COORD_W-1:0] col_r,    col_nxt;
  logic [COORD_W-1:0] row_r,    row_nxt;
  logic [BW-1:0]      bir_r,    bir_nxt;
  chan_t              chan_r,   chan_nxt;
  logic [7:0]         blue_r,   blue_nxt;
  logic [7:0]         green_r,  green_nxt;

  phase_t             ph;
  logic [POS_W-1:0]   p;
  logic [7:0]         b;
  logic [31:0]        acc_sh;
  logic [15:0]        half;
  logic               fin_req;
  logic [31:0]        fin_pos;
  logic [BW-1:0]      w3;
  logic [BW-1:0]      w3p;
  logic [BW-1:0]      row_bytes;
  logic [BW-1:0]      bir_inc;
  logic [WW-1:0]      wm1;
  logic [HW-1:0]      hm1;
  logic               last;
  logic               in_pix;
  logic               stop;

  assign b         = item.data_byte;
  assign w3        = BW'({width_r, 1'b0}) + BW'(width_r);
  assign w3p       = w3 + BW'(3);
  assign row_bytes = {w3p[BW-1:2], 2'b00};
  assign wm1       = width_r - WW'(1);
  assign hm1       = height_r - HW'(1);
  assign last      = (CMP_W'(col_r) == CMP_W'(wm1)) && (CMP_W'(row_r) == CMP_W'(hm1));

  always_comb begin
    ph         = item.first_byte ? PH_SIG : phase_r;
    p          = item.first_byte ? '0 : pos_r;
    acc_nxt    = item.first_byte ? '0 : acc_r;
    acc_sh     = {b, acc_nxt[31:8]};
    half       = acc_sh[31:16];
    pos_nxt    = p + POS_W'(1);
    phase_nxt  = ph;
    off_nxt    = off_r;
    hlen_nxt   = hlen_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    bir_nxt    = bir_r;
    chan_nxt   = chan_r;
    blue_nxt   = blue_r;
    green_nxt  = green_r;
    fin_req    = 1'b0;
    fin_pos    = POS_INFO_DATA;
    in_pix     = 1'b0;
    stop       = 1'b0;
    bir_inc    = bir_r + BW'(1);
    res_valid  = 1'b0;
    res        = '0;

    case (ph)
      PH_SIG: begin
        if ((p == '0 && b != SIG_B) || (p != '0 && b != SIG_M)) begin
          res_valid  = 1'b1;
          res.status = ST_BAD_SIG;
          phase_nxt  = PH_DONE;
        end else if (p != '0) begin
          phase_nxt = PH_HDR;
        end
      end
      PH_HDR: begin
        acc_nxt = acc_sh;
        if (p == POS_OFFSET_END) begin
          off_nxt = acc_sh;
        end else if (p == POS_HSIZE_END) begin
          hlen_nxt = acc_sh;
          if (acc_sh == HDR_V2 || acc_sh == HDR_V4 || acc_sh == HDR_V5) begin
            res_valid  = 1'b1;
            res.status = ST_HDR_VERSION;
            phase_nxt  = PH_DONE;
          end else if (acc_sh != HDR_INFO && acc_sh != HDR_CORE) begin
            res_valid  = 1'b1;
            res.status = ST_HDR_UNKNOWN;
            phase_nxt  = PH_DONE;
          end
        end else if (hlen_r == HDR_INFO) begin
          if (p == POS_INFO_W_END) begin
            width_nxt = (!acc_sh[31] && acc_sh != '0 && acc_sh <= 32'(MAX_WIDTH)) ?
                        WW'(acc_sh) : '0;
          end else if (p == POS_INFO_H_END) begin
            height_nxt = (!acc_sh[31] && acc_sh != '0 && acc_sh <= 32'(MAX_HEIGHT)) ?
                         HW'(acc_sh) : '0;
          end else if (p == POS_INFO_BPP && half != BPP_24) begin
            res_valid  = 1'b1;
            res.status = ST_NOT_24BPP;
            phase_nxt  = PH_DONE;
          end else if (p == POS_INFO_COMP) begin
            if (half != COMP_NONE) begin
              res_valid  = 1'b1;
              res.status = ST_COMPRESSED;
              phase_nxt  = PH_DONE;
            end else begin
              fin_req = 1'b1;
              fin_pos = POS_INFO_DATA;
            end
          end
        end else begin
          if (p == POS_CORE_W_END) begin
            width_nxt = (!half[15] && half != '0 && 32'(half) <= 32'(MAX_WIDTH)) ?
                        WW'(half) : '0;
          end else if (p == POS_CORE_H_END) begin
            height_nxt = (!half[15] && half != '0 && 32'(half) <= 32'(MAX_HEIGHT)) ?
                         HW'(half) : '0;
          end else if (p == POS_CORE_BPP) begin
            if (half != BPP_24) begin
              res_valid  = 1'b1;
              res.status = ST_NOT_24BPP;
              phase_nxt  = PH_DONE;
            end else begin
              fin_req = 1'b1;
              fin_pos = POS_CORE_DATA;
            end
          end
        end
      end
      PH_SKIP: begin
        if (p >= off_r) begin
          phase_nxt = PH_PIX;
          in_pix    = 1'b1;
        end
      end
      PH_PIX: begin
        in_pix = 1'b1;
      end
      default: begin
      end
    endcase

    if (fin_req) begin
      if (width_r == '0 || height_r == '0 || off_r < fin_pos) begin
        res_valid  = 1'b1;
        res.status = ST_BAD_SIZE;
        phase_nxt  = PH_DONE;
      end else begin
        col_nxt   = '0;
        row_nxt   = '0;
        bir_nxt   = '0;
        chan_nxt  = CH_BLUE;
        phase_nxt = (off_r == fin_pos) ? PH_PIX : PH_SKIP;
      end
    end

    if (in_pix) begin
      if (bir_r < w3) begin
        case (chan_r)
          CH_BLUE: begin
            blue_nxt = b;
            chan_nxt = CH_GREEN;
          end
          CH_GREEN: begin
            green_nxt = b;
            chan_nxt  = CH_RED;
          end
          default: begin
            res_valid      = 1'b1;
            res.red        = b;
            res.green      = green_r;
            res.blue       = blue_r;
            res.column     = col_r;
            res.row        = row_r;
            res.last_pixel = last;
            res.status     = ST_PIXEL;
            col_nxt        = col_r + COORD_W'(1);
            chan_nxt       = CH_BLUE;
            if (last) begin
              phase_nxt = PH_DONE;
              stop      = 1'b1;
            end
          end
        endcase
      end
      if (!stop) begin
        if (bir_inc >= row_bytes) begin
          bir_nxt  = '0;
          chan_nxt = CH_BLUE;
          col_nxt  = '0;
          row_nxt  = row_r + COORD_W'(1);
        end else begin
          bir_nxt = bir_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SIG;
      pos_r    <= '0;
      acc_r    <= '0;
      off_r    <= '0;
      hlen_r   <= '0;
      width_r  <= '0;
      height_r <= '0;
      col_r    <= '0;
      row_r    <= '0;
      bir_r    <= '0;
      chan_r   <= CH_BLUE;
      blue_r   <= '0;
      green_r  <= '0;
    end else if (adv) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      acc_r    <= acc_nxt;
      off_r    <= off_nxt;
      hlen_r   <= hlen_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      bir_r    <= bir_nxt;
      chan_r   <= chan_nxt;
      blue_r   <= blue_nxt;
      green_r  <= green_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bmpd_out_stage.sv =====
// Result register of the BMP decoder: holds one pixel or error transaction
// and decides when the parser may advance. Depends on bmpd_pkg and bmpd_out_if.
`timescale 1ns / 1ps
`default_nettype none
module bmpd_out_stage
  import bmpd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  item_valid,
  input  wire logic  res_valid,
  input  result_t    res,
  output logic       adv,
  bmpd_out_if.source out_bus
);

  logic    valid_r;
  logic    valid_nxt;
  result_t data_r;

  assign adv = item_valid && (!valid_r || out_bus.ready);

  always_comb begin
    valid_nxt = valid_r;
    if (adv) begin
      valid_nxt = res_valid;
    end else if (out_bus.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      data_r <= res;
    end
  end

  assign out_bus.valid      = valid_r;
  assign out_bus.red        = data_r.red;
  assign out_bus.green      = data_r.green;
  assign out_bus.blue       = data_r.blue;
  assign out_bus.column     = data_r.column;
  assign out_bus.row        = data_r.row;
  assign out_bus.last_pixel = data_r.last_pixel;
  assign out_bus.status     = data_r.status;

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for bmp24_stream_decoder: builds BMP byte streams,
// predicts every pixel and status transaction and checks the output channel.
// Depends on bmpd_pkg, the channel interfaces in bmpd_if.sv and the decoder.
`timescale 1ns / 1ps
module testbench;
  import bmpd_pkg::*;

  class bmp_pixel_scoreboard;
    phase_t      phase;
    logic [31:0] pos;
    logic [31:0] acc;
    logic [31:0] data_offset;
    logic [31:0] hdr_len;
    logic [12:0] img_w;
    logic [12:0] img_h;
    logic [11:0] col;
    logic [11:0] row;
    logic [13:0] row_byte;
    logic [7:0]  held_b;
    logic [7:0]  held_g;
    result_t     expected_q[$];
    int unsigned mismatches;

    function new();
      phase       = PH_SIG;
      pos         = '0;
      acc         = '0;
      data_offset = '0;
      hdr_len     = '0;
      img_w       = '0;
      img_h       = '0;
      col         = '0;
      row         = '0;
      row_byte    = '0;
      held_b      = '0;
      held_g      = '0;
      mismatches  = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void raise_error(status_t code);
      result_t r;
      r = '0;
      r.status = code;
      expected_q = {expected_q, r};
      phase = PH_DONE;
    endfunction

    function logic [31:0] size_ok(logic [31:0] v, int unsigned sign_pos, int unsigned lim);
      if (v[sign_pos] || v == 0 || v > lim) return '0;
      return v;
    endfunction

    function void open_pixels(logic [31:0] next_pos);
      if (img_w == 0 || img_h == 0 || data_offset < next_pos) begin
        raise_error(ST_BAD_SIZE);
      end else begin
        col      = '0;
        row      = '0;
        row_byte = '0;
        phase    = (data_offset == next_pos) ? PH_PIX : PH_SKIP;
      end
    endfunction

    function void note_byte(logic [7:0] b, logic first);
      logic [31:0] p;
      logic [31:0] half;
      logic [31:0] w;
      logic [31:0] row_len;
      result_t     r;
      if (first) begin
        phase = PH_SIG;
        pos   = '0;
        acc   = '0;
      end
      p   = pos;
      pos = pos + 1;
      if (phase == PH_SIG) begin
        if ((p == 0 && b != SIG_B) || (p != 0 && b != SIG_M)) raise_error(ST_BAD_SIG);
        else if (p != 0) phase = PH_HDR;
      end else if (phase == PH_HDR) begin
        acc  = {b, acc[31:8]};
        half = {16'h0, acc[31:16]};
        if (p == POS_OFFSET_END) begin
          data_offset = acc;
        end else if (p == POS_HSIZE_END) begin
          hdr_len = acc;
          if (hdr_len == HDR_V2 || hdr_len == HDR_V4 || hdr_len == HDR_V5) begin
            raise_error(ST_HDR_VERSION);
          end else if (hdr_len != HDR_INFO && hdr_len != HDR_CORE) begin
            raise_error(ST_HDR_UNKNOWN);
          end
        end else if (hdr_len == HDR_INFO) begin
          if (p == POS_INFO_W_END) img_w = 13'(size_ok(acc, 31, DEF_MAX_WIDTH));
          else if (p == POS_INFO_H_END) img_h = 13'(size_ok(acc, 31, DEF_MAX_HEIGHT));
          else if (p == POS_INFO_BPP && half != 32'(BPP_24)) raise_error(ST_NOT_24BPP);
          else if (p == POS_INFO_COMP) begin
            if (half != 32'(COMP_NONE)) raise_error(ST_COMPRESSED);
            else open_pixels(POS_INFO_DATA);
          end
        end else begin
          if (p == POS_CORE_W_END) img_w = 13'(size_ok(half, 15, DEF_MAX_WIDTH));
          else if (p == POS_CORE_H_END) img_h = 13'(size_ok(half, 15, DEF_MAX_HEIGHT));
          else if (p == POS_CORE_BPP) begin
            if (half != 32'(BPP_24)) raise_error(ST_NOT_24BPP);
            else open_pixels(POS_CORE_DATA);
          end
        end
      end else if (phase == PH_SKIP || phase == PH_PIX) begin
        if (phase == PH_SKIP && p >= data_offset) phase = PH_PIX;
        if (phase == PH_PIX) begin
          w       = 32'(img_w);
          row_len = ((w * 3 + 3) >> 2) << 2;
          if (32'(row_byte) < w * 3) begin
            if (row_byte % 3 == 0) begin
              held_b = b;
            end else if (row_byte % 3 == 1) begin
              held_g = b;
            end else begin
              r.red        = b;
              r.green      = held_g;
              r.blue       = held_b;
              r.column     = col;
              r.row        = row;
              r.last_pixel = (32'(col) == w - 1) && (32'(row) == 32'(img_h) - 1);
              r.status     = ST_PIXEL;
              expected_q   = {expected_q, r};
              col = col + 1;
              if (r.last_pixel) phase = PH_DONE;
            end
          end
          if (phase == PH_PIX) begin
            row_byte = row_byte + 1;
            if (32'(row_byte) >= row_len) begin
              row_byte = '0;
              col      = '0;
              row      = row + 1;
            end
          end
        end
      end
    endfunction

    function string show(result_t r);
      return $sformatf("rgb %02h %02h %02h col %0d row %0d last %0b status %0d",
                       r.red, r.green, r.blue, r.column, r.row, r.last_pixel, r.status);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: unexpected transaction: %s", $realtime, show(got));
      end else begin
        want = expected_q.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.column !== want.column || got.row !== want.row ||
            got.last_pixel !== want.last_pixel || got.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: mismatch: expected %s, got %s", $realtime, show(want), show(got));
          end
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  bmpd_in_if  in_bus ();
  bmpd_out_if out_bus ();

  bmp24_stream_decoder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  bmp_pixel_scoreboard sb = new();
  int unsigned src_idle_pct  = 0;
  int unsigned rcv_stall_pct = 0;
  int unsigned hold_left     = 0;
  int unsigned items_sent    = 0;
  logic [7:0]  file_q[$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    result_t got;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        got.red        = out_bus.red;
        got.green      = out_bus.green;
        got.blue       = out_bus.blue;
        got.column     = out_bus.column;
        got.row        = out_bus.row;
        got.last_pixel = out_bus.last_pixel;
        got.status     = status_t'(out_bus.status);
        sb.check_result(got);
      end
      if (hold_left > 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic f);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.data_byte  <= b;
    in_bus.first_byte <= f;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_byte(b, f);
    items_sent++;
  endtask

  task automatic send_bytes(int unsigned count, bit flag_first);
    int unsigned i;
    for (i = 0; i < count && i < file_q.size(); i++) begin
      send_byte(file_q[i], flag_first && i == 0);
    end
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic void add_byte(logic [7:0] v);
    file_q = {file_q, v};
  endfunction

  function automatic void push_le(logic [31:0] v, int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) add_byte(v[8*i +: 8]);
  endfunction

  function automatic void push_rand(int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) add_byte(8'($urandom_range(255)));
  endfunction

  function automatic void make_bmp(logic [31:0] hsize, logic [31:0] offset,
                                   logic [31:0] w_raw, logic [31:0] h_raw,
                                   logic [15:0] bpp, logic [15:0] comp,
                                   int unsigned pix_w, int unsigned pix_h, int unsigned tail);
    file_q.delete();
    add_byte(SIG_B);
    add_byte(SIG_M);
    push_rand(8);
    push_le(offset, 4);
    push_le(hsize, 4);
    if (hsize == HDR_CORE) begin
      push_le(w_raw, 2);
      push_le(h_raw, 2);
      push_le(32'd1, 2);
      push_le(32'(bpp), 2);
    end else begin
      push_le(w_raw, 4);
      push_le(h_raw, 4);
      push_le(32'd1, 2);
      push_le(32'(bpp), 2);
      push_le(32'(comp), 2);
    end
    while (file_q.size() < offset && file_q.size() < 600) push_rand(1);
    push_rand(((pix_w * 3 + 3) / 4) * 4 * pix_h);
    push_rand(tail);
  endfunction

  function automatic void make_good(bit core, int unsigned w, int unsigned h,
                                    int unsigned gap, int unsigned tail);
    if (core) make_bmp(HDR_CORE, POS_CORE_DATA + gap, w, h, BPP_24, COMP_NONE, w, h, tail);
    else make_bmp(HDR_INFO, POS_INFO_DATA + gap, w, h, BPP_24, COMP_NONE, w, h, tail);
  endfunction

  function automatic void make_failing(logic [31:0] hsize, logic [31:0] offset,
                                       logic [31:0] w_raw, logic [31:0] h_raw,
                                       logic [15:0] bpp, logic [15:0] comp);
    make_bmp(hsize, offset, w_raw, h_raw, bpp, comp, 0, 0, 6);
    if (file_q.size() > 32) file_q = file_q[0:31];
  endfunction

  task automatic random_case();
    int unsigned k;
    int unsigned n;
    int unsigned i;
    k = $urandom_range(99);
    make_good($urandom_range(1), $urandom_range(1, 7), $urandom_range(1, 4),
              ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 24), $urandom_range(3));
    if (k < 70) begin
      send_bytes(file_q.size(), $urandom_range(9) != 0);
    end else if (k < 85) begin
      if ($urandom_range(1)) begin
        file_q[$urandom_range(31)] = 8'($urandom_range(255));
        send_bytes(file_q.size(), 1'b1);
      end else begin
        send_bytes($urandom_range(1, file_q.size() - 1), 1'b1);
      end
    end else begin
      n = $urandom_range(1, 24);
      for (i = 0; i < n; i++) send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
    end
  endtask

  initial begin
    int unsigned ph;
    int unsigned target;
    rst_n             <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.data_byte  <= '0;
    in_bus.first_byte <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // The first file after reset carries no first-byte mark.
    make_good(0, 2, 2, 22, 2);
    send_bytes(file_q.size(), 1'b0);
    make_good(1, 3, 2, 0, 1);
    send_bytes(file_q.size(), 1'b1);
    make_good(0, 5, 3, 0, 0);
    send_bytes(file_q.size(), 1'b1);
    make_good(1, 1, 3, 6, 3);
    send_bytes(file_q.size(), 1'b1);
    make_good(0, 1, 1, 0, 0);
    file_q[0] = 8'h62;
    send_bytes(file_q.size(), 1'b1);
    make_good(0, 1, 1, 0, 0);
    file_q[1] = SIG_B;
    send_bytes(file_q.size(), 1'b1);
    make_failing(HDR_V2, 54, 2, 2, BPP_24, COMP_NONE);
    send_bytes(file_q.size(), 1'b1);
    make_failing(HDR_V4, 54, 2, 2, BPP_24, COMP_NONE);
    send_bytes(file_q.size(), 1'b1);
    make_failing(HDR_V5, 54, 2, 2, BPP_24, COMP_NONE);
    send_bytes(file_q.size(), 1'b1);
    make_failing(32'd0, 54, 2, 2, BPP_24, COMP_NONE);
    send_bytes(file_q.size(), 1'b1);
    make_failing(32'h8000_0028, 54, 2, 2, BPP_24, COMP_NONE);
    send_bytes(file_q.size(), 1'b1);
    make_failing(HDR_INFO, 54, 2, 2, 16'd32, COMP_NONE);
    send_bytes(file_q.size(), 1'b1);
    make_failing(HDR_CORE, 26, 2, 2, 16'hFFFF, COMP_NONE);
    send_bytes(file_q.size(), 1'b1);
    make_failing(HDR_INFO, 54, 2, 2, BPP_24, 16'h8001);
    send_bytes(file_q.size(), 1'b1);
    // Bit count is checked before the sizes, compression before the sizes too.
    make_failing(HDR_INFO, 54, 0, 2, 16'd8, COMP_NONE);
    send_bytes(file_q.size(), 1'b1);
    make_failing(HDR_INFO, 54, 2, 0, BPP_24, 16'd1);
    send_bytes(file_q.size(), 1'b1);
    make_failing(HDR_INFO, 54, 32'hFFFF_FFFF, 2, BPP_24, COMP_NONE);
    send_bytes(file_q.size(), 1'b1);
    make_failing(HDR_INFO, 54, 2, 32'd4097, BPP_24, COMP_NONE);
    send_bytes(file_q.size(), 1'b1);
    make_failing(HDR_CORE, 26, 32'h8000, 2, BPP_24, COMP_NONE);
    send_bytes(file_q.size(), 1'b1);
    make_failing(HDR_CORE, 26, 2, 0, BPP_24, COMP_NONE);
    send_bytes(file_q.size(), 1'b1);
    make_failing(HDR_INFO, 31, 2, 2, BPP_24, COMP_NONE);
    send_bytes(file_q.size(), 1'b1);
    make_failing(HDR_CORE, 0, 2, 2, BPP_24, COMP_NONE);
    send_bytes(file_q.size(), 1'b1);
    make_failing(HDR_INFO, 32'h8000_0000, 2, 2, BPP_24, COMP_NONE);
    send_bytes(file_q.size(), 1'b1);
    make_good(0, 4, 4, 0, 0);
    send_bytes(60, 1'b1);
    // The largest sizes are accepted; only the start of their pixel data is sent.
    make_good(0, 4096, 1, 22, 0);
    send_bytes(80, 1'b1);
    make_good(1, 1, 4096, 0, 4);
    send_bytes(80, 1'b1);
    wait_drained();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin src_idle_pct = 83; rcv_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  rcv_stall_pct = 83; end
        default: begin src_idle_pct = 28; rcv_stall_pct = 28; end
      endcase
      target = items_sent + 50;
      if (ph == 0) begin
        hold_left = 300;
        make_good(0, 4, 2, 0, 0);
        send_bytes(file_q.size(), 1'b1);
      end
      while (items_sent < target) random_case();
      wait_drained();
    end

    in_bus.valid <= 1'b0;
    wait_drained();
    repeat (16) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
